// ===== design/mfs_pkg.sv =====
`default_nettype none
package mfs_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int IDX_W       = $clog2(FRAME_BYTES);

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_BYTE    = 2'd1,
    OP_BUTTONS = 2'd2,
    OP_IDLE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    CFG_TIMEOUT = 2'd0,
    CFG_BLINK   = 2'd1,
    CFG_LIMIT   = 2'd2
  } cfg_idx_e;

  localparam logic [7:0] FUNC_READ  = 8'h03;
  localparam logic [7:0] FUNC_WRITE = 8'h06;
  localparam logic [7:0] ADDR_COUNT = 8'd4;
  localparam logic [7:0] ADDR_ID    = 8'd5;

  localparam int BTN_UP     = 0;
  localparam int BTN_DOWN   = 1;
  localparam int BTN_FAULT  = 2;
  localparam int NUM_FAULTS = 4;
  localparam int NUM_BTNS   = BTN_FAULT + NUM_FAULTS;

  localparam logic [15:0] TIMEOUT_RST = 16'd30;
  localparam logic [15:0] BLINK_RST   = 16'd2000;
  localparam logic [15:0] LIMIT_RST   = 16'd9999;
  localparam logic [7:0]  ID_RST      = 8'd1;

  typedef struct packed {
    op_e                 operation;
    logic [7:0]          rx_byte;
    logic [NUM_BTNS-1:0] button_levels;
  } item_t;

  typedef struct packed {
    logic [15:0] timeout;
    logic [15:0] blink;
    logic [15:0] limit;
  } cfg_t;

  // decoded frame, valid on the beat carrying the last byte
  typedef struct packed {
    logic       read_req;
    logic       wr_en;
    logic [7:0] addr;
    logic [7:0] data_hi;
    logic [7:0] data_lo;
  } frame_evt_t;

  typedef struct packed {
    logic [15:0]                 count;
    logic [NUM_FAULTS-1:0][7:0] fault;
    logic [7:0]                  id;
  } regs_t;

endpackage
`default_nettype wire

// ===== design/mfs_if.sv =====
`default_nettype none
interface mfs_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] rx_byte;
  logic [5:0] button_levels;

  modport source (output valid, operation, rx_byte, button_levels, input ready);
  modport sink (input valid, operation, rx_byte, button_levels, output ready);
endinterface

interface mfs_result_if;
  logic        valid;
  logic        ready;
  logic        read_request;
  logic [15:0] count_value;
  logic [7:0]  fault_one;
  logic [7:0]  fault_two;
  logic [7:0]  fault_three;
  logic [7:0]  fault_four;
  logic [7:0]  device_id;
  logic        led_level;

  modport source (output valid, read_request, count_value, fault_one, fault_two,
                  fault_three, fault_four, device_id, led_level, input ready);
  modport sink (input valid, read_request, count_value, fault_one, fault_two,
                fault_three, fault_four, device_id, led_level, output ready);
endinterface

interface mfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/mfs_frame.sv =====
`default_nettype none
module mfs_frame (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic [31:0]         tick_i,
  input  wire logic [15:0]         timeout_i,
  input  wire logic [7:0]          id_i,
  output mfs_pkg::frame_evt_t      evt_o
);

  logic [mfs_pkg::IDX_W-1:0] idx_q, idx_d, idx_eff;
  logic [31:0]               start_q, start_d;
  logic [7:0]                buf_q [mfs_pkg::FRAME_BYTES];
  logic [31:0]               gap;
  logic                      expired, last, hit;

  assign gap     = tick_i - start_q;
  assign expired = gap > {16'd0, timeout_i};
  assign idx_eff = expired ? '0 : idx_q;
  assign last    = idx_eff == mfs_pkg::IDX_W'(mfs_pkg::FRAME_BYTES - 1);

  assign idx_d   = step_i ? idx_eff + 1'b1 : idx_q;
  assign start_d = (step_i && expired) ? tick_i : start_q;

  // the final byte itself is not needed for decode
  assign hit            = step_i && last && (buf_q[0] == id_i);
  assign evt_o.read_req = hit && (buf_q[1] == mfs_pkg::FUNC_READ);
  assign evt_o.wr_en    = hit && (buf_q[1] == mfs_pkg::FUNC_WRITE);
  assign evt_o.addr     = buf_q[3];
  assign evt_o.data_hi  = buf_q[4];
  assign evt_o.data_lo  = buf_q[5];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      start_q <= '0;
    end else begin
      idx_q   <= idx_d;
      start_q <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      buf_q[idx_eff] <= rx_byte_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/mfs_panel.sv =====
`default_nettype none
module mfs_panel (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          btn_step_i,
  input  wire logic [mfs_pkg::NUM_BTNS-1:0]  levels_i,
  input  wire logic [15:0]                   limit_i,
  input  wire mfs_pkg::frame_evt_t           evt_i,
  output mfs_pkg::regs_t                     regs_o
);

  mfs_pkg::regs_t                regs_q, regs_d;
  logic [mfs_pkg::NUM_BTNS-1:0]  latch_q, latch_d, press;
  logic [15:0]                   cnt_up;

  assign press = ~levels_i & ~latch_q;

  always_comb begin
    regs_d  = regs_q;
    latch_d = latch_q;
    cnt_up  = regs_q.count;
    if (btn_step_i) begin
      latch_d = ~levels_i;
      if (press[mfs_pkg::BTN_UP] && (regs_q.count < limit_i)) begin
        cnt_up = regs_q.count + 16'd1;
      end
      regs_d.count = cnt_up;
      if (press[mfs_pkg::BTN_DOWN] && (cnt_up != 16'd0)) begin
        regs_d.count = cnt_up - 16'd1;
      end
      for (int k = 0; k < mfs_pkg::NUM_FAULTS; k++) begin
        if (press[mfs_pkg::BTN_FAULT + k]) begin
          regs_d.fault[k] = (regs_q.fault[k] == 8'd1) ? 8'd0 : 8'd1;
        end
      end
    end else if (evt_i.wr_en) begin
      if (evt_i.addr[7:2] == 6'd0) begin
        regs_d.fault[evt_i.addr[1:0]] = evt_i.data_lo;
      end else if (evt_i.addr == mfs_pkg::ADDR_COUNT) begin
        regs_d.count = {evt_i.data_hi, evt_i.data_lo};
      end else if (evt_i.addr == mfs_pkg::ADDR_ID) begin
        regs_d.id = evt_i.data_lo;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.count <= '0;
      regs_q.fault <= '0;
      regs_q.id    <= mfs_pkg::ID_RST;
      latch_q      <= '0;
    end else begin
      regs_q  <= regs_d;
      latch_q <= latch_d;
    end
  end

  assign regs_o = regs_q;

endmodule
`default_nettype wire

// ===== design/mfs_blink.sv =====
`default_nettype none
module mfs_blink (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic        tick_i,
  input  wire logic [15:0] period_i,
  output logic [31:0]      tick_o,
  output logic             led_o
);

  logic [31:0] tick_q, tick_d, mark_q, mark_d;
  logic        led_q, led_d, due;

  assign tick_d = (step_i && tick_i) ? tick_q + 32'd1 : tick_q;
  // LED check runs after the item, so it sees the updated tick count
  assign due    = (tick_d - mark_q) >= {16'd0, period_i};
  assign mark_d = (step_i && due) ? tick_d : mark_q;
  assign led_d  = (step_i && due) ? ~led_q : led_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q <= '0;
      mark_q <= '0;
      led_q  <= 1'b0;
    end else begin
      tick_q <= tick_d;
      mark_q <= mark_d;
      led_q  <= led_d;
    end
  end

  assign tick_o = tick_q;
  assign led_o  = led_q;

endmodule
`default_nettype wire

// ===== design/modbus_frame_slave_with_buttons_top.sv =====
// Frame slave with buttons.
// item_i (sink): one beat is a 1 ms tick, a received serial byte, or a sample
//   of six active-low button levels (up, down, four error buttons).
// result_o (source): one beat per item, carrying the read request flag for a
//   completed function 3 frame, and the counter, error, id and LED registers
//   as they stand after that item.
// cfg_i (sink): register writes, index 0 frame timeout, 1 blink period,
//   2 counter limit; always ready, other indexes are dropped.
// Flow: an accepted item is held in the input register; when it advances, the
//   register file and the result register are updated together and
//   result_o.valid rises.
// Throughput: one item per cycle unless result_o stalls; the input and result
//   registers form a two-entry pipe, so an item is taken while a result waits.
// Stall: while result_o is held, one more item is taken into the input
//   register, then item_i.ready drops until the result is taken.
// Reset: clears tick count, frame state, counter, error registers, latches
//   and LED, sets the id to 1 and the config to 30 / 2000 / 9999.
`default_nettype none
module modbus_frame_slave_with_buttons_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mfs_item_if.sink    item_i,
  mfs_result_if.source result_o,
  mfs_cfg_if.sink     cfg_i
);

  mfs_pkg::item_t     item_q;
  logic               s1_valid_q, out_valid_q, req_q;
  logic               adv, take;
  mfs_pkg::cfg_t      cfg_q;
  mfs_pkg::frame_evt_t evt;
  mfs_pkg::regs_t     regs;
  logic [31:0]        tick;
  logic               led;

  assign adv   = s1_valid_q && (!out_valid_q || result_o.ready);
  assign item_i.ready = !s1_valid_q || adv;
  assign take  = item_i.valid && item_i.ready;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      req_q       <= 1'b0;
      cfg_q.timeout <= mfs_pkg::TIMEOUT_RST;
      cfg_q.blink   <= mfs_pkg::BLINK_RST;
      cfg_q.limit   <= mfs_pkg::LIMIT_RST;
    end else begin
      if (item_i.ready) begin
        s1_valid_q <= item_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
        req_q       <= evt.read_req;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid) begin
        case (mfs_pkg::cfg_idx_e'(cfg_i.index))
          mfs_pkg::CFG_TIMEOUT: cfg_q.timeout <= cfg_i.data;
          mfs_pkg::CFG_BLINK:   cfg_q.blink   <= cfg_i.data;
          mfs_pkg::CFG_LIMIT:   cfg_q.limit   <= cfg_i.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.operation     <= mfs_pkg::op_e'(item_i.operation);
      item_q.rx_byte       <= item_i.rx_byte;
      item_q.button_levels <= item_i.button_levels;
    end
  end

  mfs_blink u_blink (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .tick_i   (item_q.operation == mfs_pkg::OP_TICK),
    .period_i (cfg_q.blink),
    .tick_o   (tick),
    .led_o    (led)
  );

  mfs_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (adv && (item_q.operation == mfs_pkg::OP_BYTE)),
    .rx_byte_i (item_q.rx_byte),
    .tick_i    (tick),
    .timeout_i (cfg_q.timeout),
    .id_i      (regs.id),
    .evt_o     (evt)
  );

  mfs_panel u_panel (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .btn_step_i (adv && (item_q.operation == mfs_pkg::OP_BUTTONS)),
    .levels_i   (item_q.button_levels),
    .limit_i    (cfg_q.limit),
    .evt_i      (evt),
    .regs_o     (regs)
  );

  // state registers change only when a new result is loaded, so they
  // double as the result payload
  assign result_o.valid        = out_valid_q;
  assign result_o.read_request = req_q;
  assign result_o.count_value  = regs.count;
  assign result_o.fault_one    = regs.fault[0];
  assign result_o.fault_two    = regs.fault[1];
  assign result_o.fault_three  = regs.fault[2];
  assign result_o.fault_four   = regs.fault[3];
  assign result_o.device_id    = regs.id;
  assign result_o.led_level    = led;

endmodule
`default_nettype wire

// ===== design/mfs_checker.sv =====
`default_nettype none
module mfs_assert (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        read_request,
  input wire logic [15:0] count_value,
  input wire logic        led_level
);

  // held result beat stays valid and keeps its count and LED level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(count_value) && $stable(led_level))
    else $error("stalled result changed");

  // every accepted item is followed by a valid result beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> ##1 out_valid)
    else $error("result missing after accepted item");

  // with the result slot empty the input side never blocks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result slot");

  // a completed frame resets the byte count, so the next result has no request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && read_request |=> !(out_valid && read_request))
    else $error("back-to-back read requests");

endmodule

bind modbus_frame_slave_with_buttons_top mfs_assert u_mfs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (item_i.valid),
  .in_ready     (item_i.ready),
  .out_valid    (result_o.valid),
  .out_ready    (result_o.ready),
  .read_request (result_o.read_request),
  .count_value  (result_o.count_value),
  .led_level    (result_o.led_level)
);
`default_nettype wire
